// ===== sv/kles_pkg.sv =====
// shared types and constants of the nearest-neighbor entropy sweep
`default_nettype none

package kles_pkg;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIM_MIN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIM_MAX       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LARGEST_DELAY = 3'd3;

    // reset values of the configuration registers
    localparam logic [8:0] SAMPLE_COUNT_RST  = 9'd256;
    localparam logic [4:0] DIM_MIN_RST       = 5'd1;
    localparam logic [4:0] DIM_MAX_RST       = 5'd16;
    localparam logic [7:0] LARGEST_DELAY_RST = 8'd1;

    // fixed point constants
    localparam int               FRAC_BITS    = 16;
    localparam int               SUM_W        = 48;
    localparam logic signed [31:0] LN2_Q30    = 32'sd744261118;
    localparam logic signed [31:0] KL_CONST_Q16 = 32'sd83253;

    typedef struct packed {
        logic               command;
        logic signed [15:0] sample_value;
        logic [7:0]         delay;
    } cmd_word_t;

    typedef struct packed {
        logic signed [31:0] entropy_estimate;
        logic [4:0]         dimension;
        logic               last;
        logic               error_flag;
    } est_word_t;

endpackage

`default_nettype wire

// ===== sv/kles_log2.sv =====
// iterative log2 unit: normalize one bit a cycle, then 16 squaring steps
`default_nettype none

module kles_log2 #(
    parameter int LOGW = 37,
    parameter int EW   = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [LOGW-1:0]  value,
    output logic             busy,
    output logic             done,
    output logic [EW+15:0]   result
);
    import kles_pkg::*;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_ITER = 2'd2;

    logic [1:0]      state_reg;
    logic [LOGW-1:0] v_reg;
    logic [EW-1:0]   e_reg;
    logic [31:0]     y_reg;
    logic [15:0]     r_reg;
    logic [3:0]      k_reg;
    logic            done_reg;
    logic [63:0]     sq;
    logic [32:0]     yy;

    // one squaring step
    assign sq = 64'(y_reg) * 64'(y_reg);
    assign yy = sq[63:31];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= L_NORM;
                    end
                end
                L_NORM:
                begin
                    if (v_reg[LOGW-1])
                    begin
                        k_reg     <= '0;
                        state_reg <= L_ITER;
                    end
                end
                L_ITER:
                begin
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == 4'd15)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    v_reg <= value;
                    e_reg <= EW'(LOGW - 1);
                end
            end
            L_NORM:
            begin
                if (v_reg[LOGW-1])
                begin
                    y_reg <= v_reg[LOGW-1 -: 32];
                end
                else
                begin
                    v_reg <= {v_reg[LOGW-2:0], 1'b0};
                    e_reg <= e_reg - 1'b1;
                end
            end
            L_ITER:
            begin
                r_reg <= {r_reg[14:0], yy[32]};
                y_reg <= yy[32] ? yy[32:1] : yy[31:0];
            end
            default:
            begin
                v_reg <= v_reg;
            end
        endcase
    end

    assign busy   = (state_reg != L_IDLE);
    assign done   = done_reg;
    assign result = {e_reg, r_reg};

endmodule

`default_nettype wire

// ===== sv/kles_div.sv =====
// restoring unsigned divider, one quotient bit a cycle
`default_nettype none

module kles_div #(
    parameter int NUMW = 49,
    parameter int DENW = 9
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            busy,
    output logic            done,
    output logic [NUMW-1:0] quot
);
    import kles_pkg::*;

    localparam int CNTW = $clog2(NUMW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DENW-1:0] rem_reg;
    logic [DENW-1:0] den_reg;
    logic [NUMW-1:0] q_reg;
    logic [DENW:0]   trial;
    logic            ge;

    // shift in the next numerator bit and try the subtraction
    assign trial = {rem_reg, q_reg[NUMW-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNTW'(NUMW);
                end
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            if (start)
            begin
                q_reg   <= num;
                den_reg <= den;
                rem_reg <= '0;
            end
        end
        else
        begin
            rem_reg <= ge ? DENW'(trial - {1'b0, den_reg}) : DENW'(trial);
            q_reg   <= {q_reg[NUMW-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ===== sv/knn_entropy_embedding_sweep.sv =====
// nearest-neighbor entropy estimator swept over embedding dimensions
// a load word is taken in the idle state and leaves it idle; a run holds the input until its last estimate is out
// a run makes coordinate passes, then per dimension a search with the log unit (width max(distance width,32))
//   and a divide
// throughput is set by the single read port of the distance memory, one pair a cycle
// reset clears control and config registers; sample and distance memories are not cleared
`default_nettype none

module knn_entropy_embedding_sweep #(
    parameter int MAX_SAMPLES = 256,
    parameter int MAX_DIMS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  kles_pkg::cmd_word_t                 cmd,
    output logic                                est_valid,
    input  logic                                est_ready,
    output kles_pkg::est_word_t                 est,
    input  logic                                cfg_we,
    input  logic [kles_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kles_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kles_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int IW   = $clog2(MAX_SAMPLES);
    localparam int CW   = IW + 1;
    localparam int DW   = 2 * SB + 1 + $clog2(MAX_DIMS);
    localparam int DA   = $clog2(MAX_SAMPLES * MAX_SAMPLES);
    localparam int LOGW = (DW > 32) ? DW : 32;
    localparam int EW   = $clog2(LOGW);
    localparam int LR   = EW + 16;
    localparam int XW   = (SB > 16) ? SB : 16;
    localparam int NUMW = SUM_W + 1;
    localparam logic signed [SUM_W-1:0] LOG_BIAS = SUM_W'((2 * SB - 2) * 65536);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PREP      = 4'd1;
    localparam logic [3:0] S_PASS_INIT = 4'd2;
    localparam logic [3:0] S_PASS      = 4'd3;
    localparam logic [3:0] S_DRAIN     = 4'd4;
    localparam logic [3:0] S_ROW_INIT  = 4'd5;
    localparam logic [3:0] S_ROW       = 4'd6;
    localparam logic [3:0] S_ROW_WAIT  = 4'd7;
    localparam logic [3:0] S_ROW_LOG   = 4'd8;
    localparam logic [3:0] S_NEXT_ROW  = 4'd9;
    localparam logic [3:0] S_FINISH    = 4'd10;
    localparam logic [3:0] S_DIV       = 4'd11;
    localparam logic [3:0] S_MUL       = 4'd12;
    localparam logic [3:0] S_RND       = 4'd13;
    localparam logic [3:0] S_EMIT      = 4'd14;
    localparam logic [3:0] S_NNLOG     = 4'd15;

    // configuration registers
    logic [8:0] sample_count_reg;
    logic [4:0] dim_min_reg;
    logic [4:0] dim_max_reg;
    logic [7:0] largest_delay_reg;

    // control state
    logic [3:0]    state_reg;
    logic [IW-1:0] load_ptr_reg;
    logic [IW-1:0] off_reg;
    logic [7:0]    delay_reg;
    logic [7:0]    step_reg;
    logic [4:0]    m_reg;
    logic [4:0]    passes_reg;
    logic [CW-1:0] nn_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] j_reg;
    logic          bad_reg;
    logic          range_bad_reg;
    logic          first_reg;
    logic          found_reg;
    logic [CW-1:0] zc_reg;
    logic signed [SUM_W-1:0] log_sum_reg;
    logic          v1_reg, v2_reg, v3_reg;
    logic          rv1_reg;
    logic          log_start_reg;
    logic          div_start_reg;
    logic          neg_reg;
    logic          est_valid_reg;

    // payload registers
    logic signed [SB-1:0] sa_rd_reg, sb_rd_reg;
    logic [DW-1:0]        dist_rd_reg;
    logic signed [SB:0]   diff_reg;
    logic [DW-1:0]        dold2_reg, dold3_reg;
    logic [2*SB:0]        sq_reg;
    logic [DA-1:0]        a1_reg, a2_reg, a3_reg;
    logic [DW-1:0]        best_reg;
    logic [LR-1:0]        lnn_reg;
    logic [LOGW-1:0]      log_val_reg;
    logic [NUMW-1:0]      div_num_reg;
    logic [CW-1:0]        div_den_reg;
    logic signed [31:0]   mean_reg;
    logic signed [63:0]   prod_reg;
    logic signed [31:0]   res_est_reg;
    logic                 res_err_reg;
    est_word_t            est_reg;

    // memories
    logic signed [SB-1:0] sample_mem [MAX_SAMPLES];
    logic [DW-1:0]        dist_mem [MAX_SAMPLES * MAX_SAMPLES];

    // submodule wires
    logic            log_busy, log_done;
    logic [LR-1:0]   log_res;
    logic            div_busy, div_done;
    logic [NUMW-1:0] div_quot;

    // combinational helpers
    logic [CW-1:0]  nn_m1, nn_m2;
    logic           row_end_j, last_pair, slot_free, upd;
    logic [IW:0]    sum_a, sum_b, sum_p;
    logic [IW-1:0]  addr_sa, addr_sb, lo_idx, hi_idx;
    logic [DA-1:0]  dist_raddr;
    logic [XW-1:0]  x_ext;
    logic signed [15:0] nn_s, nn_prod;
    logic           range_bad, run_bad;
    logic [CW-1:0]  c_cnt;
    logic [SUM_W-1:0] sum_mag;
    logic signed [2*SB+1:0] sq_full;
    logic signed [SUM_W-1:0] term;
    logic [63:0]    prod_mag;
    logic [32:0]    rnd_q;
    logic signed [31:0] rnd_s;
    logic [IW-1:0]  load_ptr_next, off_next;

    assign nn_m1     = nn_reg - CW'(1);
    assign nn_m2     = nn_reg - CW'(2);
    assign row_end_j = ({1'b0, j_reg} == nn_m1);
    assign last_pair = row_end_j && ({1'b0, i_reg} == nn_m2);
    assign slot_free = !est_valid_reg || est_ready;

    // sample addresses wrap around the store
    assign sum_a   = (IW+1)'(i_reg) + (IW+1)'(off_reg);
    assign sum_b   = (IW+1)'(j_reg) + (IW+1)'(off_reg);
    assign addr_sa = IW'((sum_a >= (IW+1)'(MAX_SAMPLES)) ? sum_a - (IW+1)'(MAX_SAMPLES) : sum_a);
    assign addr_sb = IW'((sum_b >= (IW+1)'(MAX_SAMPLES)) ? sum_b - (IW+1)'(MAX_SAMPLES) : sum_b);

    // upper-triangle distance address
    assign lo_idx     = (state_reg == S_ROW && j_reg < i_reg) ? j_reg : i_reg;
    assign hi_idx     = (state_reg == S_ROW && j_reg < i_reg) ? i_reg : j_reg;
    assign dist_raddr = DA'(lo_idx) * DA'(MAX_SAMPLES) + DA'(hi_idx);

    // pointer and offset stepping
    assign load_ptr_next = (load_ptr_reg == IW'(MAX_SAMPLES - 1)) ? '0 : load_ptr_reg + 1'b1;
    assign off_next      = (off_reg == IW'(MAX_SAMPLES - 1)) ? '0 : off_reg + 1'b1;
    assign sum_p         = '0;

    // sample zero extension
    assign x_ext = XW'($unsigned(cmd.sample_value));

    // run checks
    assign range_bad = (dim_min_reg == 5'd0) || (dim_min_reg > dim_max_reg)
                     || (int'(dim_max_reg) > MAX_DIMS);
    assign nn_prod   = 16'(dim_max_reg - 5'd1) * 16'(largest_delay_reg);
    assign nn_s      = 16'(sample_count_reg) - nn_prod;
    assign run_bad   = (int'(sample_count_reg) > MAX_SAMPLES) || (nn_s < 16'sd2)
                     || (cmd.delay > largest_delay_reg);

    // neighbor search compare
    assign upd = rv1_reg && (dist_rd_reg != '0) && (!found_reg || dist_rd_reg < best_reg);

    // per point term and final arithmetic
    assign c_cnt    = nn_reg - zc_reg;
    assign sum_mag  = log_sum_reg[SUM_W-1] ? SUM_W'(-log_sum_reg) : SUM_W'(log_sum_reg);
    assign sq_full  = diff_reg * diff_reg;
    assign term     = (SUM_W'(lnn_reg) << 1) + SUM_W'(log_res) - LOG_BIAS;
    assign prod_mag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
    assign rnd_q    = 33'((prod_mag + 64'd1073741824) >> 31);
    assign rnd_s    = prod_reg[63] ? -32'(rnd_q) : 32'(rnd_q);

    // log and divide units
    kles_log2 #(
        .LOGW (LOGW),
        .EW   (EW)
    ) u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start_reg),
        .value  (log_val_reg),
        .busy   (log_busy),
        .done   (log_done),
        .result (log_res)
    );

    kles_div #(
        .NUMW (NUMW),
        .DENW (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg  <= SAMPLE_COUNT_RST;
            dim_min_reg       <= DIM_MIN_RST;
            dim_max_reg       <= DIM_MAX_RST;
            largest_delay_reg <= LARGEST_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_COUNT:  sample_count_reg  <= cfg_data[8:0];
                REG_DIM_MIN:       dim_min_reg       <= cfg_data[4:0];
                REG_DIM_MAX:       dim_max_reg       <= cfg_data[4:0];
                REG_LARGEST_DELAY: largest_delay_reg <= cfg_data[7:0];
                default:           sample_count_reg  <= sample_count_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_ptr_reg  <= '0;
            off_reg       <= '0;
            delay_reg     <= '0;
            step_reg      <= '0;
            m_reg         <= '0;
            passes_reg    <= '0;
            nn_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            bad_reg       <= 1'b0;
            range_bad_reg <= 1'b0;
            first_reg     <= 1'b0;
            found_reg     <= 1'b0;
            zc_reg        <= '0;
            log_sum_reg   <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            rv1_reg       <= 1'b0;
            log_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            neg_reg       <= 1'b0;
            est_valid_reg <= 1'b0;
        end
        else
        begin
            // pipeline valids
            v1_reg        <= (state_reg == S_PASS);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            rv1_reg       <= (state_reg == S_ROW) && (j_reg != i_reg);
            log_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (upd)
            begin
                found_reg <= 1'b1;
            end
            if (est_ready)
            begin
                est_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.command == CMD_LOAD)
                        begin
                            load_ptr_reg <= load_ptr_next;
                        end
                        else
                        begin
                            load_ptr_reg  <= '0;
                            off_reg       <= '0;
                            delay_reg     <= cmd.delay;
                            m_reg         <= dim_min_reg;
                            range_bad_reg <= range_bad;
                            bad_reg       <= run_bad;
                            nn_reg        <= CW'(nn_s);
                            if (range_bad)
                            begin
                                state_reg <= S_EMIT;
                            end
                            else if (run_bad)
                            begin
                                state_reg <= S_PREP;
                            end
                            else
                            begin
                                log_start_reg <= 1'b1;
                                state_reg     <= S_NNLOG;
                            end
                        end
                    end
                end
                S_NNLOG:
                begin
                    if (log_done)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (bad_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        if (m_reg == dim_min_reg)
                        begin
                            passes_reg <= dim_min_reg;
                            first_reg  <= 1'b1;
                        end
                        else
                        begin
                            passes_reg <= 5'd1;
                        end
                        state_reg <= S_PASS_INIT;
                    end
                end
                S_PASS_INIT:
                begin
                    i_reg     <= '0;
                    j_reg     <= IW'(1);
                    state_reg <= S_PASS;
                end
                S_PASS:
                begin
                    if (last_pair)
                    begin
                        step_reg  <= delay_reg;
                        state_reg <= S_DRAIN;
                    end
                    else if (row_end_j)
                    begin
                        i_reg <= i_reg + 1'b1;
                        j_reg <= IW'(i_reg + 2'd2);
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    // advance the coordinate offset while the pipeline empties
                    if (step_reg != 8'd0)
                    begin
                        off_reg  <= off_next;
                        step_reg <= step_reg - 1'b1;
                    end
                    else if (!v1_reg && !v2_reg && !v3_reg)
                    begin
                        first_reg  <= 1'b0;
                        passes_reg <= passes_reg - 1'b1;
                        if (passes_reg == 5'd1)
                        begin
                            i_reg       <= '0;
                            zc_reg      <= '0;
                            log_sum_reg <= '0;
                            state_reg   <= S_ROW_INIT;
                        end
                        else
                        begin
                            state_reg <= S_PASS_INIT;
                        end
                    end
                end
                S_ROW_INIT:
                begin
                    j_reg     <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    if (row_end_j)
                    begin
                        state_reg <= S_ROW_WAIT;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_ROW_WAIT:
                begin
                    if (!rv1_reg)
                    begin
                        if (found_reg)
                        begin
                            log_start_reg <= 1'b1;
                            state_reg     <= S_ROW_LOG;
                        end
                        else
                        begin
                            zc_reg    <= zc_reg + 1'b1;
                            state_reg <= S_NEXT_ROW;
                        end
                    end
                end
                S_ROW_LOG:
                begin
                    if (log_done)
                    begin
                        log_sum_reg <= log_sum_reg + term;
                        state_reg   <= S_NEXT_ROW;
                    end
                end
                S_NEXT_ROW:
                begin
                    if ({1'b0, i_reg} == nn_m1)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_ROW_INIT;
                    end
                end
                S_FINISH:
                begin
                    if (c_cnt == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        neg_reg       <= log_sum_reg[SUM_W-1];
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        est_valid_reg <= 1'b1;
                        if (range_bad_reg || m_reg == dim_max_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            m_reg     <= m_reg + 1'b1;
                            state_reg <= S_PREP;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // sample memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid && cmd.command == CMD_LOAD)
        begin
            sample_mem[load_ptr_reg] <= x_ext[SB-1:0];
        end
        sa_rd_reg <= sample_mem[addr_sa];
        sb_rd_reg <= sample_mem[addr_sb];
    end

    // distance memory, read-modify-write over three stages
    always_ff @(posedge clk)
    begin
        dist_rd_reg <= dist_mem[dist_raddr];
        if (v3_reg)
        begin
            dist_mem[a3_reg] <= dold3_reg + DW'(sq_reg);
        end
    end

    // pass pipeline and arithmetic datapath
    always_ff @(posedge clk)
    begin
        a1_reg    <= dist_raddr;
        diff_reg  <= $signed({sa_rd_reg[SB-1], sa_rd_reg}) - $signed({sb_rd_reg[SB-1], sb_rd_reg});
        dold2_reg <= first_reg ? '0 : dist_rd_reg;
        a2_reg    <= a1_reg;
        sq_reg    <= sq_full[2*SB:0];
        dold3_reg <= dold2_reg;
        a3_reg    <= a2_reg;

        if (upd)
        begin
            best_reg <= dist_rd_reg;
        end

        // log operand select
        if (state_reg == S_IDLE)
        begin
            log_val_reg <= LOGW'(nn_s[CW-1:0]);
        end
        else if (state_reg == S_ROW_WAIT)
        begin
            log_val_reg <= LOGW'(best_reg);
        end

        if (state_reg == S_NNLOG && log_done)
        begin
            lnn_reg <= log_res;
        end

        // mean, scale and rounding
        div_num_reg <= NUMW'(sum_mag) + NUMW'(c_cnt >> 1);
        div_den_reg <= c_cnt;
        if (state_reg == S_DIV && div_done)
        begin
            mean_reg <= neg_reg ? -32'(div_quot) : 32'(div_quot);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= 64'(mean_reg) * 64'(LN2_Q30);
        end

        // result staging
        if (state_reg == S_IDLE || state_reg == S_PREP || state_reg == S_FINISH)
        begin
            res_est_reg <= '0;
            res_err_reg <= 1'b1;
        end
        else if (state_reg == S_RND)
        begin
            res_est_reg <= rnd_s + KL_CONST_Q16;
            res_err_reg <= 1'b0;
        end

        if (state_reg == S_EMIT && slot_free)
        begin
            est_reg.entropy_estimate <= res_est_reg;
            est_reg.dimension        <= m_reg;
            est_reg.last             <= range_bad_reg || (m_reg == dim_max_reg);
            est_reg.error_flag       <= res_err_reg;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign est_valid = est_valid_reg;
    assign est       = est_reg;

`ifndef ASSERT_OFF
    // the search reads only after every distance write of the passes has landed
    a_search_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW) |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("distance search overlaps pending writes");

    // a search only runs with at least two points
    a_search_points: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW) |-> (nn_reg >= CW'(2)))
        else $error("search with fewer than two points");

    // the log unit is never restarted while busy
    a_log_start: assert property (@(posedge clk) disable iff (!rst_n)
        log_start_reg |-> !log_busy)
        else $error("log unit started while busy");

    // the divider is never restarted while busy
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> !div_busy)
        else $error("divider started while busy");

    // a new word appears only out of the emit state
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(est_valid) |-> ($past(state_reg) == S_EMIT))
        else $error("estimate word raised outside emit");
`endif

endmodule

`default_nettype wire

// ===== tb/knn_entropy_embedding_sweep_tb.sv =====
// self-checking testbench of the nearest-neighbor entropy sweep
`timescale 1ns / 1ps

module knn_entropy_embedding_sweep_tb;

    import kles_pkg::*;

    localparam int          STORE_DEPTH = 256;
    localparam int          DIM_LIMIT   = 16;
    localparam int          Q_SHIFT     = 2 * 16 - 2;
    localparam int          QUIET_LIMIT = 600000;
    localparam int          HOLD_CYCLES = 3000;
    localparam int          RANDOM_WORDS = 500;

    typedef logic [CFG_INDEX_W-1:0] cfg_idx_t;
    typedef enum logic { ROW_CFG, ROW_CMD } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_idx_t    index;
        logic [8:0]  data;
        cmd_word_t   word;
        bit          typed;
        est_word_t   want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    cmd_word_t   cmd;
    logic        est_valid;
    logic        est_ready;
    est_word_t   est;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    knn_entropy_embedding_sweep DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .est_valid (est_valid),
        .est_ready (est_ready),
        .est       (est),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state: series, pair distances, registers
    int                  series [STORE_DEPTH];
    longint unsigned     pair_dist [STORE_DEPTH][STORE_DEPTH];
    int                  load_ptr;
    logic [8:0]          sc_reg;
    logic [4:0]          dmin_reg;
    logic [4:0]          dmax_reg;
    logic [7:0]          ld_reg;

    est_word_t           fresh_est [$];
    est_word_t           pending_est [$];

    int                  mismatches;
    int                  failures;
    int                  quiet_cycles;
    bit                  steady;
    bit                  hold_req;
    int                  hold_left;
    int                  ready_wait;

    // log2 of an integer in q16, bit-serial squaring
    function automatic longint unsigned log2_q16(longint unsigned v);
        int              e;
        longint unsigned t;
        longint unsigned y;
        longint unsigned r;
        e = 0;
        t = v;
        while (t > 1)
        begin
            t = t >> 1;
            e++;
        end
        y = (e > 31) ? (v >> (e - 31)) : (v << (31 - e));
        r = longint'(e) << 16;
        for (int k = 15; k >= 0; k--)
        begin
            y = (y * y) >> 31;
            if (y >= 64'h1_0000_0000)
            begin
                y = y >> 1;
                r = r | (64'd1 << k);
            end
        end
        return r;
    endfunction

    // divide, rounding halves away from zero
    function automatic longint round_half_away(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // grow every pair distance by one coordinate
    task automatic grow_distances(int nn, int off);
        int              a;
        int              b;
        longint          df;
        longint unsigned mag;
        for (int i = 0; i < nn; i++)
            for (int j = i + 1; j < nn; j++)
            begin
                a = (i + off) % STORE_DEPTH;
                b = (j + off) % STORE_DEPTH;
                df = longint'(series[a]) - longint'(series[b]);
                mag = (df < 0) ? -df : df;
                pair_dist[i][j] += mag * mag;
            end
    endtask

    // estimates of one run word
    task automatic predict_sweep(logic [7:0] dly);
        int              nns;
        int              nn;
        int              zc;
        bit              bad;
        bit              err;
        bit              found;
        longint          lsum;
        longint          lnn2;
        longint          mean;
        longint          val;
        longint unsigned best;
        longint unsigned dv;
        est_word_t       r;
        load_ptr = 0;
        if (dmin_reg == 0 || dmin_reg > dmax_reg || dmax_reg > DIM_LIMIT)
        begin
            r = '{entropy_estimate: 0, dimension: dmin_reg, last: 1'b1, error_flag: 1'b1};
            fresh_est.push_back(r);
            return;
        end
        nns = int'(sc_reg) - (int'(dmax_reg) - 1) * int'(ld_reg);
        bad = (sc_reg > STORE_DEPTH) || (nns < 2) || (dly > ld_reg);
        nn = bad ? 0 : nns;
        for (int m = dmin_reg; m <= dmax_reg; m++)
        begin
            err = 1'b1;
            val = 0;
            if (!bad)
            begin
                lnn2 = 2 * longint'(log2_q16(nn));
                if (m == dmin_reg)
                begin
                    for (int i = 0; i < nn; i++)
                        for (int j = i + 1; j < nn; j++)
                            pair_dist[i][j] = 0;
                    for (int d = 0; d < m; d++)
                        grow_distances(nn, d * dly);
                end
                else
                    grow_distances(nn, (m - 1) * dly);
                lsum = 0;
                zc = 0;
                for (int i = 0; i < nn; i++)
                begin
                    best = 0;
                    found = 1'b0;
                    for (int j = 0; j < nn; j++)
                    begin
                        if (j != i)
                        begin
                            dv = (i < j) ? pair_dist[i][j] : pair_dist[j][i];
                            if (dv != 0 && (!found || dv < best))
                            begin
                                best = dv;
                                found = 1'b1;
                            end
                        end
                    end
                    if (found)
                        lsum += lnn2 + longint'(log2_q16(best)) - (longint'(Q_SHIFT) << 16);
                    else
                        zc++;
                end
                if (nn - zc != 0)
                begin
                    mean = round_half_away(lsum, nn - zc);
                    val = round_half_away(mean * longint'(LN2_Q30), 64'd1 << 31)
                        + longint'(KL_CONST_Q16);
                    err = 1'b0;
                end
            end
            r.entropy_estimate = val[31:0];
            r.dimension = m[4:0];
            r.last = (m == dmax_reg);
            r.error_flag = err;
            fresh_est.push_back(r);
        end
    endtask

    // predictor step for one accepted command word
    task automatic predict_word(cmd_word_t w);
        if (w.command == CMD_LOAD)
        begin
            series[load_ptr] = int'(w.sample_value);
            load_ptr = (load_ptr + 1) % STORE_DEPTH;
        end
        else
            predict_sweep(w.delay);
    endtask

    // idle cycles drawn per word
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    // offer one command word and wait until it is taken
    task automatic send_word(cmd_word_t w, bit typed, est_word_t want);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd = w;
        cmd_valid = 1'b1;
        fresh_est.delete();
        predict_word(w);
        if (typed)
            pending_est.push_back(want);
        else
            foreach (fresh_est[k])
                pending_est.push_back(fresh_est[k]);
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    // register write once every estimate is out
    task automatic write_reg(cfg_idx_t idx, logic [8:0] data);
        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending_est.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            REG_SAMPLE_COUNT:  sc_reg = data;
            REG_DIM_MIN:       dmin_reg = data[4:0];
            REG_DIM_MAX:       dmax_reg = data[4:0];
            REG_LARGEST_DELAY: ld_reg = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(int sc, int dmin, int dmax, int ld);
        write_reg(REG_SAMPLE_COUNT, sc);
        write_reg(REG_DIM_MIN, dmin);
        write_reg(REG_DIM_MAX, dmax);
        write_reg(REG_LARGEST_DELAY, ld);
    endtask

    function automatic cmd_word_t load_word(int v);
        cmd_word_t w;
        w.command = CMD_LOAD;
        w.sample_value = v[15:0];
        w.delay = $urandom_range(0, 255);
        return w;
    endfunction

    function automatic cmd_word_t run_word(int dly);
        cmd_word_t w;
        w.command = CMD_RUN;
        w.sample_value = $urandom_range(0, 65535);
        w.delay = dly[7:0];
        return w;
    endfunction

    // sample values: full range, few distinct values, one constant, or the two extremes
    function automatic int draw_sample(int mode);
        case (mode)
            0:       return $urandom_range(0, 65535);
            1:       return int'($urandom_range(0, 4)) - 2;
            2:       return 7;
            default: return ($urandom_range(0, 1) == 1) ? 32767 : -32768;
        endcase
    endfunction

    // directed table
    stim_row_t table_rows [$];

    function automatic void add_cfg(cfg_idx_t idx, int data);
        stim_row_t r;
        r.kind = ROW_CFG;
        r.index = idx;
        r.data = data[8:0];
        r.typed = 1'b0;
        table_rows.push_back(r);
    endfunction

    function automatic void add_cmd(cmd_word_t w, bit typed, int dimv, bit lastv, bit errv);
        stim_row_t r;
        r.kind = ROW_CMD;
        r.word = w;
        r.typed = typed;
        r.want = '{entropy_estimate: 0, dimension: dimv[4:0], last: lastv, error_flag: errv};
        table_rows.push_back(r);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        est_word_t w;
        if (rst_n && est_valid && est_ready)
        begin
            if (pending_est.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected estimate word %h", est);
                mismatches++;
            end
            else
            begin
                w = pending_est.pop_front();
                if (est.entropy_estimate !== w.entropy_estimate
                    || est.dimension !== w.dimension
                    || est.last !== w.last || est.error_flag !== w.error_flag)
                begin
                    failures++;
                    if (mismatches < 10)
                        $display("estimate mismatch: want est=%0d dim=%0d last=%b err=%b, got est=%0d dim=%0d last=%b err=%b",
                                 w.entropy_estimate, w.dimension, w.last, w.error_flag,
                                 est.entropy_estimate, est.dimension, est.last,
                                 est.error_flag);
                    mismatches++;
                end
            end
            ready_wait = draw_gap();
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            est_ready = 1'b0;
            hold_left--;
        end
        else if (ready_wait > 0)
        begin
            est_ready = 1'b0;
            ready_wait--;
        end
        else
            est_ready = 1'b1;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (est_valid && est_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int        sent;
        int        mode;
        int        nn;
        int        dmax;
        int        dmin;
        int        ld;
        int        ldmax;
        int        sc;
        int        nload;
        int        dly;
        est_word_t none;
        cmd_valid = 1'b0;
        cmd = '0;
        est_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        failures = 0;
        quiet_cycles = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        ready_wait = 0;
        none = '0;
        load_ptr = 0;
        sc_reg = SAMPLE_COUNT_RST;
        dmin_reg = DIM_MIN_RST;
        dmax_reg = DIM_MAX_RST;
        ld_reg = LARGEST_DELAY_RST;
        foreach (series[k])
            series[k] = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill the whole series store once, extremes first
        send_word(load_word(32767), 1'b0, none);
        send_word(load_word(-32768), 1'b0, none);
        for (int k = 2; k < STORE_DEPTH; k++)
            send_word(load_word(draw_sample(0)), 1'b0, none);

        // directed rows
        add_cfg(REG_DIM_MIN, 0);
        add_cmd(run_word(1), 1'b1, 0, 1'b1, 1'b1);
        add_cfg(REG_DIM_MIN, 5);
        add_cfg(REG_DIM_MAX, 3);
        add_cmd(run_word(1), 1'b1, 5, 1'b1, 1'b1);
        add_cfg(REG_DIM_MIN, 1);
        add_cfg(REG_DIM_MAX, 17);
        add_cmd(run_word(1), 1'b1, 1, 1'b1, 1'b1);
        add_cfg(REG_DIM_MIN, 2);
        add_cfg(REG_DIM_MAX, 2);
        add_cfg(REG_SAMPLE_COUNT, 300);
        add_cmd(run_word(1), 1'b1, 2, 1'b1, 1'b1);
        add_cfg(REG_SAMPLE_COUNT, 2);
        add_cmd(run_word(1), 1'b1, 2, 1'b1, 1'b1);
        add_cfg(REG_SAMPLE_COUNT, 10);
        add_cmd(run_word(2), 1'b1, 2, 1'b1, 1'b1);
        add_cmd(run_word(1), 1'b0, 0, 1'b0, 1'b0);
        add_cfg(REG_LARGEST_DELAY, 255);
        add_cfg(REG_DIM_MIN, 1);
        add_cfg(REG_DIM_MAX, 1);
        add_cmd(run_word(255), 1'b0, 0, 1'b0, 1'b0);
        add_cfg(REG_SAMPLE_COUNT, 6);
        for (int k = 0; k < 6; k++)
            add_cmd(load_word(0), 1'b0, 0, 1'b0, 1'b0);
        add_cmd(run_word(1), 1'b0, 0, 1'b0, 1'b0);
        add_cfg(cfg_idx_t'(4), 0);
        add_cfg(REG_SAMPLE_COUNT, 20);
        add_cfg(REG_DIM_MIN, 16);
        add_cfg(REG_DIM_MAX, 16);
        add_cfg(REG_LARGEST_DELAY, 1);
        add_cmd(run_word(1), 1'b0, 0, 1'b0, 1'b0);

        foreach (table_rows[k])
        begin
            if (table_rows[k].kind == ROW_CFG)
                write_reg(table_rows[k].index, table_rows[k].data);
            else
                send_word(table_rows[k].word, table_rows[k].typed, table_rows[k].want);
        end

        // one run over the full series
        write_all(STORE_DEPTH, 1, 1, 1);
        send_word(run_word(1), 1'b0, none);

        // random phases
        sent = 0;
        for (int ph = 0; sent < RANDOM_WORDS; ph++)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_all(8, 0, 3, 1);
                    1: write_all(8, $urandom_range(2, 16), 1, 1);
                    2: write_all(8, 1, $urandom_range(17, 31), 1);
                    3: write_all($urandom_range(257, 511), 1, 2, 1);
                    default: write_all($urandom_range(2, 10), 1, 3, 5);
                endcase
            end
            else
            begin
                dmax = $urandom_range(1, DIM_LIMIT);
                dmin = $urandom_range(1, dmax);
                nn = $urandom_range(2, 14);
                ldmax = (dmax > 1) ? (STORE_DEPTH - nn) / (dmax - 1) : 255;
                if (ldmax > 255)
                    ldmax = 255;
                if ($urandom_range(0, 1) == 0 && ldmax > 4)
                    ldmax = 4;
                ld = $urandom_range(1, ldmax);
                sc = nn + (dmax - 1) * ld;
                write_all(sc, dmin, dmax, ld);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(cfg_idx_t'($urandom_range(4, 7)), $urandom_range(0, 511));

            mode = $urandom_range(0, 3);
            nload = ($urandom_range(0, 11) == 0) ? 260 : $urandom_range(0, 24);
            for (int k = 0; k < nload; k++)
            begin
                send_word(load_word(draw_sample(mode)), 1'b0, none);
                sent++;
            end
            if (ph == 2)
                hold_req = 1'b1;
            for (int k = $urandom_range(1, 3); k > 0; k--)
            begin
                if ($urandom_range(0, 7) == 0)
                    dly = $urandom_range(ld_reg, 255);
                else
                    dly = $urandom_range(1, (ld_reg == 0) ? 1 : ld_reg);
                send_word(run_word(dly), 1'b0, none);
                sent++;
                if (ph == 2)
                    for (int q = 0; q < 6; q++)
                    begin
                        send_word(load_word(draw_sample(mode)), 1'b0, none);
                        sent++;
                    end
            end
        end

        // drain
        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending_est.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/kles_pkg.sv
sv/kles_log2.sv
sv/kles_div.sv
sv/knn_entropy_embedding_sweep.sv
tb/knn_entropy_embedding_sweep_tb.sv
